@@ rtl/core/coincidence_event_builder_macros.svh @@
// Assertion macros shared by the coincidence event builder RTL.
`ifndef COINCIDENCE_EVENT_BUILDER_MACROS_SVH
`define COINCIDENCE_EVENT_BUILDER_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, sampled on clk and held off during rst.
`define CEB_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("coincidence_event_builder: assertion failed");
// Next-cycle implication, sampled on clk and held off during rst.
`define CEB_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("coincidence_event_builder: assertion failed");
`else
`define CEB_ASSERT_IMP(label, ante, cons)
`define CEB_ASSERT_NXT(label, ante, cons)
`endif

`endif

@@ rtl/core/ceb_pkg.sv @@
// Types, constants and register codes of the coincidence event builder.
package ceb_pkg;

  localparam int          MaxFragmentWords = 1024;
  localparam int          MinbiasBit       = 8;
  localparam int          QueueDepth       = 2;
  localparam logic [29:0] WindowReset      = 30'd5000000;
  localparam logic [15:0] MinbiasReset     = 16'd1;
  localparam logic [15:0] RandomReset      = 16'd2;
  localparam logic [31:0] NsPerSec         = 32'd1000000000;
  localparam logic [31:0] HeaderBytes      = 32'd40;

  typedef enum logic {
    CMD_FRAGMENT = 1'b0,
    CMD_FLUSH    = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    REG_WINDOW  = 3'd0,
    REG_MINBIAS = 3'd1,
    REG_RANDOM  = 3'd2,
    REG_RUN     = 3'd3,
    REG_VERSION = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    STREAM_COINC   = 2'd0,
    STREAM_MINBIAS = 2'd1,
    STREAM_RANDOM  = 2'd2
  } stream_t;

  typedef struct packed {
    logic [29:0] window_ns;
    logic [15:0] minbias_flag;
    logic [15:0] random_flag;
    logic [31:0] run_number;
    logic [7:0]  version_tag;
  } cfg_t;

  // Classified item as it waits between the front and the back.
  typedef struct packed {
    cmd_t        cmd;
    logic [31:0] trigger_id;
    logic [31:0] station_id;
    logic [31:0] seconds;
    logic [29:0] nanosec;
    logic [15:0] evtype;
    logic [31:0] version;
    logic [17:0] bytes;
  } frag_t;

  typedef struct packed {
    logic [31:0] event_trigger_id;
    logic [15:0] fragment_count;
    logic [31:0] event_length_bytes;
    logic [31:0] event_number;
    logic [31:0] first_station;
    logic [31:0] event_seconds;
    logic [29:0] event_nanosec;
    logic [15:0] event_type;
    stream_t     stream;
    logic [31:0] event_version;
    logic [31:0] run_id;
  } hdr_t;

endpackage

@@ rtl/core/ceb_fifo.sv @@
// Small register queue used between the block's stages and at its output.
module ceb_fifo import ceb_pkg::*; #(
  parameter type T     = frag_t,
  parameter int  Depth = QueueDepth
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  T     wdata,
  output logic full,
  input  logic pop,
  output T     rdata,
  output logic empty
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  T              mem [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            do_push;
  logic            do_pop;

  assign full    = (count == CntW'(Depth));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ rtl/core/ceb_front.sv @@
// Front end: accepts items, drops oversized fragments, precomputes type and version.
module ceb_front import ceb_pkg::*; (
  input  cfg_t        cfg,
  input  logic        push,
  input  logic        full,
  input  logic        command,
  input  logic [31:0] trigger_id,
  input  logic [31:0] station_id,
  input  logic [31:0] time_seconds,
  input  logic [29:0] time_nanosec,
  input  logic [31:0] trigger_status,
  input  logic [15:0] length_words,
  input  logic [31:0] fragment_version,
  output logic        q_push,
  output frag_t       q_data
);

  cmd_t cmd;
  logic oversize;

  assign cmd      = cmd_t'(command);
  assign oversize = (length_words >= 16'(MaxFragmentWords));

  // A flush always goes on; an oversized fragment is swallowed here.
  assign q_push = push && !full && ((cmd == CMD_FLUSH) || !oversize);

  always_comb begin
    q_data            = '0;
    q_data.cmd        = cmd;
    q_data.trigger_id = trigger_id;
    q_data.station_id = station_id;
    q_data.seconds    = time_seconds;
    q_data.nanosec    = time_nanosec;
    q_data.evtype     = trigger_status[31:16] |
                        (trigger_status[MinbiasBit] ? cfg.minbias_flag : 16'd0);
    q_data.version    = fragment_version + {16'd0, cfg.version_tag, 8'd0};
    q_data.bytes      = {length_words, 2'b00};
  end

endmodule

@@ rtl/core/ceb_back.sv @@
// Back end: holds the open event, joins or closes it, and builds event headers.
module ceb_back import ceb_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  cfg_t  cfg,
  input  frag_t head,
  input  logic  q_empty,
  output logic  q_pop,
  input  logic  out_full,
  output logic  out_push,
  output hdr_t  out_data
);

  logic        event_open;
  logic [31:0] open_trigger_id;
  logic [31:0] open_station;
  logic [31:0] open_seconds;
  logic [29:0] open_nanosec;
  logic [15:0] open_type;
  logic [31:0] open_version;
  logic [15:0] open_count;
  logic [31:0] open_length;
  logic [31:0] event_counter;

  logic        take;
  logic        is_flush;
  logic        join_open;
  logic        load;
  logic [32:0] sec_diff;
  logic [30:0] ns_diff;
  logic [31:0] base;
  logic [31:0] signed_gap;
  logic [31:0] mag;
  logic [31:0] gap;
  logic        far;
  logic        in_window;
  logic [32:0] len_sum;

  // Time gap between the open event and the head item, in nanoseconds.
  assign sec_diff = {1'b0, head.seconds} - {1'b0, open_seconds};
  assign ns_diff  = {1'b0, head.nanosec} - {1'b0, open_nanosec};
  assign far      = (sec_diff != 33'd0) && (sec_diff != 33'd1) && (sec_diff != '1);

  always_comb begin
    if (sec_diff == 33'd1) begin
      base = NsPerSec;
    end else if (sec_diff == '1) begin
      base = -NsPerSec;
    end else begin
      base = '0;
    end
  end

  assign signed_gap = {ns_diff[30], ns_diff} + base;
  assign mag        = signed_gap[31] ? -signed_gap : signed_gap;
  assign gap        = far ? NsPerSec : mag;
  assign in_window  = (gap < {2'b00, cfg.window_ns});

  assign take      = !q_empty && !out_full;
  assign q_pop     = take;
  assign is_flush  = (head.cmd == CMD_FLUSH);
  assign join_open = event_open && (head.trigger_id == open_trigger_id) && in_window;
  assign out_push  = take && event_open && (is_flush || !join_open);
  assign load      = take && !is_flush && !join_open;
  assign len_sum   = {1'b0, open_length} + 33'(head.bytes);

  always_ff @(posedge clk) begin
    if (rst) begin
      event_open    <= 1'b0;
      event_counter <= '0;
    end else begin
      if (out_push) begin
        event_counter <= event_counter + 32'd1;
      end
      if (load) begin
        event_open <= 1'b1;
      end else if (take && is_flush) begin
        event_open <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      open_trigger_id <= head.trigger_id;
      open_station    <= head.station_id;
      open_seconds    <= head.seconds;
      open_nanosec    <= head.nanosec;
      open_type       <= head.evtype;
      open_version    <= head.version;
      open_count      <= 16'd1;
      open_length     <= HeaderBytes + 32'(head.bytes);
    end else if (take && !is_flush && join_open) begin
      if (open_count != '1) begin
        open_count <= open_count + 16'd1;
      end
      open_length <= len_sum[32] ? '1 : len_sum[31:0];
    end
  end

  always_comb begin
    out_data                    = '0;
    out_data.event_trigger_id   = open_trigger_id;
    out_data.fragment_count     = open_count;
    out_data.event_length_bytes = open_length;
    out_data.event_number       = event_counter;
    out_data.first_station      = open_station;
    out_data.event_seconds      = open_seconds;
    out_data.event_nanosec      = open_nanosec;
    out_data.event_version      = open_version;
    out_data.run_id             = cfg.run_number;
    out_data.event_type         = open_type;
    if ((open_type & cfg.minbias_flag) != '0) begin
      out_data.stream = STREAM_MINBIAS;
    end else if ((open_type & cfg.random_flag) != '0) begin
      out_data.stream = STREAM_RANDOM;
    end else if (open_count == 16'd1) begin
      out_data.stream     = STREAM_RANDOM;
      out_data.event_type = open_type | cfg.random_flag;
    end else begin
      out_data.stream = STREAM_COINC;
    end
  end

endmodule

@@ rtl/core/coincidence_event_builder.sv @@
// Top level of the coincidence event builder: registers, front, queues and back.
//
//   Channel   Direction  Handshake            Carries
//   input     in         push / full          fragment descriptor or flush command
//   result    out        empty / pop          event header of one closed event
//   config    in/out     APB psel / penable   window, flags, run number, version tag
//
// The front is combinational and feeds the middle queue; a new item is
// accepted every cycle while the queues have room.
// The back takes one item per cycle while the output queue has room; the time-gap
// compare against the open event and the count and length update sit in that single stage.
// A header enters the output queue as the back takes the item that closes it.
// Reset is synchronous and empties both queues and closes any open event.
// A stalled result side fills the output queue, then the middle queue, then
// raises full.
`include "coincidence_event_builder_macros.svh"

module coincidence_event_builder import ceb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // Input queue side.
  input  logic        push,
  output logic        full,
  input  logic        command,
  input  logic [31:0] trigger_id,
  input  logic [31:0] station_id,
  input  logic [31:0] time_seconds,
  input  logic [29:0] time_nanosec,
  input  logic [31:0] trigger_status,
  input  logic [15:0] length_words,
  input  logic [31:0] fragment_version,
  // Result queue side.
  output logic        empty,
  input  logic        pop,
  output logic [31:0] event_trigger_id,
  output logic [15:0] fragment_count,
  output logic [31:0] event_length_bytes,
  output logic [31:0] event_number,
  output logic [31:0] first_station,
  output logic [31:0] event_seconds,
  output logic [29:0] event_nanosec,
  output logic [15:0] event_type,
  output logic [1:0]  stream,
  output logic [31:0] event_version,
  output logic [31:0] run_id,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t     cfg;
  reg_idx_t reg_idx;
  logic     cfg_write;

  frag_t    front_data;
  logic     front_push;
  frag_t    mid_head;
  logic     mid_empty;
  logic     mid_pop;

  hdr_t     back_data;
  logic     back_push;
  logic     out_full;
  hdr_t     out_head;

  // Registers sit on word addresses; the two low address bits are ignored.
  assign pready    = 1'b1;
  assign reg_idx   = reg_idx_t'(paddr[4:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.window_ns    <= WindowReset;
      cfg.minbias_flag <= MinbiasReset;
      cfg.random_flag  <= RandomReset;
      cfg.run_number   <= '0;
      cfg.version_tag  <= '0;
    end else if (cfg_write) begin
      unique case (reg_idx)
        REG_WINDOW:  cfg.window_ns    <= pwdata[29:0];
        REG_MINBIAS: cfg.minbias_flag <= pwdata[15:0];
        REG_RANDOM:  cfg.random_flag  <= pwdata[15:0];
        REG_RUN:     cfg.run_number   <= pwdata;
        REG_VERSION: cfg.version_tag  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_WINDOW:  prdata = {2'b00, cfg.window_ns};
      REG_MINBIAS: prdata = {16'd0, cfg.minbias_flag};
      REG_RANDOM:  prdata = {16'd0, cfg.random_flag};
      REG_RUN:     prdata = cfg.run_number;
      REG_VERSION: prdata = {24'd0, cfg.version_tag};
      default:     prdata = '0;
    endcase
  end

  // The front classifies each accepted item and drops oversized fragments,
  // so the back only ever sees flush commands and fragments within the size limit.
  ceb_front u_front (
    .cfg              (cfg),
    .push             (push),
    .full             (full),
    .command          (command),
    .trigger_id       (trigger_id),
    .station_id       (station_id),
    .time_seconds     (time_seconds),
    .time_nanosec     (time_nanosec),
    .trigger_status   (trigger_status),
    .length_words     (length_words),
    .fragment_version (fragment_version),
    .q_push           (front_push),
    .q_data           (front_data)
  );

  // The middle queue lets the front keep accepting while the back waits for
  // room at the output.
  ceb_fifo #(
    .T     (frag_t),
    .Depth (QueueDepth)
  ) u_mid_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (front_push),
    .wdata (front_data),
    .full  (full),
    .pop   (mid_pop),
    .rdata (mid_head),
    .empty (mid_empty)
  );

  // The back decides join, close or open for the item at the head of the
  // middle queue and pushes a header whenever an event closes.
  ceb_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .head     (mid_head),
    .q_empty  (mid_empty),
    .q_pop    (mid_pop),
    .out_full (out_full),
    .out_push (back_push),
    .out_data (back_data)
  );

  // The output queue holds finished headers until the consumer pops them.
  ceb_fifo #(
    .T     (hdr_t),
    .Depth (QueueDepth)
  ) u_out_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (back_push),
    .wdata (back_data),
    .full  (out_full),
    .pop   (pop),
    .rdata (out_head),
    .empty (empty)
  );

  assign event_trigger_id   = out_head.event_trigger_id;
  assign fragment_count     = out_head.fragment_count;
  assign event_length_bytes = out_head.event_length_bytes;
  assign event_number       = out_head.event_number;
  assign first_station      = out_head.first_station;
  assign event_seconds      = out_head.event_seconds;
  assign event_nanosec      = out_head.event_nanosec;
  assign event_type         = out_head.event_type;
  assign stream             = out_head.stream;
  assign event_version      = out_head.event_version;
  assign run_id             = out_head.run_id;

  // Every emitted event holds at least its first fragment and the header bytes.
  `CEB_ASSERT_IMP(a_count_nonzero, !empty, fragment_count != 16'd0)
  `CEB_ASSERT_IMP(a_length_floor, !empty, event_length_bytes >= HeaderBytes)
  // The stream code is never the unused fourth value.
  `CEB_ASSERT_IMP(a_stream_valid, !empty, stream != 2'd3)
  // Headers leave in order, each with the next event number.
  `CEB_ASSERT_NXT(a_number_step, !empty && pop, empty || event_number == $past(event_number) + 32'd1)

endmodule

@@ tb/event_header_checker.sv @@
`timescale 1ns / 1ps
// Checker of the coincidence event builder: watches all ports, predicts event headers, compares.
module event_header_checker import ceb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic        full,
  input  logic        command,
  input  logic [31:0] trigger_id,
  input  logic [31:0] station_id,
  input  logic [31:0] time_seconds,
  input  logic [29:0] time_nanosec,
  input  logic [31:0] trigger_status,
  input  logic [15:0] length_words,
  input  logic [31:0] fragment_version,
  input  logic        empty,
  input  logic        pop,
  input  logic [31:0] event_trigger_id,
  input  logic [15:0] fragment_count,
  input  logic [31:0] event_length_bytes,
  input  logic [31:0] event_number,
  input  logic [31:0] first_station,
  input  logic [31:0] event_seconds,
  input  logic [29:0] event_nanosec,
  input  logic [15:0] event_type,
  input  logic [1:0]  stream,
  input  logic [31:0] event_version,
  input  logic [31:0] run_id,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  input  logic        pready,
  output logic [31:0] fail_count,
  output logic [31:0] headers_due
);

  cfg_t        regs;
  logic        ev_open;
  logic [31:0] ev_trig, ev_station, ev_sec, ev_ver, ev_len, ev_num;
  logic [29:0] ev_ns;
  logic [15:0] ev_type, ev_cnt;
  hdr_t        header_q[$];
  int          err_cnt = 0;

  task automatic report(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    err_cnt++;
  endtask

  task automatic cmp(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want) report($sformatf("%s is %h, expected %h", name, got, want));
  endtask

  // Distance of two timestamps in ns; seconds fields more than one apart count as 1e9.
  function automatic logic [63:0] time_apart(input logic [31:0] s1, input logic [29:0] n1,
                                             input logic [31:0] s2, input logic [29:0] n2);
    logic [31:0] sd;
    logic [63:0] t1, t2;
    sd = (s1 > s2) ? s1 - s2 : s2 - s1;
    if (sd > 32'd1) return 64'(NsPerSec);
    t1 = 64'(s1);
    t1 = t1 * 64'(NsPerSec) + 64'(n1);
    t2 = 64'(s2);
    t2 = t2 * 64'(NsPerSec) + 64'(n2);
    return (t1 > t2) ? t1 - t2 : t2 - t1;
  endfunction

  task automatic close_event();
    hdr_t        h;
    logic [15:0] typ;
    stream_t     s;
    typ = ev_type;
    if ((typ & regs.minbias_flag) != '0) begin
      s = STREAM_MINBIAS;
    end else if ((typ & regs.random_flag) != '0) begin
      s = STREAM_RANDOM;
    end else if (ev_cnt == 16'd1) begin
      s = STREAM_RANDOM;
      typ = typ | regs.random_flag;
    end else begin
      s = STREAM_COINC;
    end
    h.event_trigger_id   = ev_trig;
    h.fragment_count     = ev_cnt;
    h.event_length_bytes = ev_len;
    h.event_number       = ev_num;
    h.first_station      = ev_station;
    h.event_seconds      = ev_sec;
    h.event_nanosec      = ev_ns;
    h.event_type         = typ;
    h.stream             = s;
    h.event_version      = ev_ver;
    h.run_id             = regs.run_number;
    header_q.push_back(h);
    ev_num = ev_num + 32'd1;
  endtask

  task automatic open_event();
    logic [15:0] typ;
    typ = trigger_status[31:16];
    if (trigger_status[MinbiasBit]) typ = typ | regs.minbias_flag;
    ev_open    = 1'b1;
    ev_trig    = trigger_id;
    ev_station = station_id;
    ev_sec     = time_seconds;
    ev_ns      = time_nanosec;
    ev_type    = typ;
    ev_ver     = fragment_version + {16'b0, regs.version_tag, 8'b0};
    ev_cnt     = 16'd1;
    ev_len     = HeaderBytes + {14'b0, length_words, 2'b00};
  endtask

  always @(posedge clk) begin : watch
    logic [63:0] gap;
    logic [63:0] sum;
    logic [31:0] reg_now;
    hdr_t        want;
    if (rst) begin
      regs.window_ns    = WindowReset;
      regs.minbias_flag = MinbiasReset;
      regs.random_flag  = RandomReset;
      regs.run_number   = '0;
      regs.version_tag  = '0;
      ev_open = 1'b0;
      ev_trig = '0; ev_station = '0; ev_sec = '0; ev_ns = '0; ev_type = '0;
      ev_ver = '0; ev_cnt = '0; ev_len = '0; ev_num = '0;
      header_q.delete();
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          case (reg_idx_t'(paddr[4:2]))
            REG_WINDOW:  regs.window_ns    = pwdata[29:0];
            REG_MINBIAS: regs.minbias_flag = pwdata[15:0];
            REG_RANDOM:  regs.random_flag  = pwdata[15:0];
            REG_RUN:     regs.run_number   = pwdata;
            REG_VERSION: regs.version_tag  = pwdata[7:0];
            default: ;
          endcase
        end else begin
          case (reg_idx_t'(paddr[4:2]))
            REG_WINDOW:  reg_now = {2'b0, regs.window_ns};
            REG_MINBIAS: reg_now = {16'b0, regs.minbias_flag};
            REG_RANDOM:  reg_now = {16'b0, regs.random_flag};
            REG_RUN:     reg_now = regs.run_number;
            default:     reg_now = {24'b0, regs.version_tag};
          endcase
          cmp($sformatf("prdata at %h", paddr), prdata, reg_now);
        end
      end

      if (push && !full) begin
        if (command == CMD_FLUSH) begin
          if (ev_open) begin
            close_event();
            ev_open = 1'b0;
          end
        end else if (length_words < 16'(MaxFragmentWords)) begin
          if (!ev_open) begin
            open_event();
          end else begin
            gap = time_apart(ev_sec, ev_ns, time_seconds, time_nanosec);
            if (trigger_id == ev_trig && gap < {34'd0, regs.window_ns}) begin
              if (ev_cnt != 16'hFFFF) ev_cnt = ev_cnt + 16'd1;
              sum = 64'(ev_len) + 64'({length_words, 2'b00});
              ev_len = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
            end else begin
              close_event();
              open_event();
            end
          end
        end
      end

      if (pop && !empty) begin
        if (header_q.size() == 0) begin
          report($sformatf("header for trigger id %h with none expected", event_trigger_id));
        end else begin
          want = header_q.pop_front();
          cmp("event_trigger_id", event_trigger_id, want.event_trigger_id);
          cmp("fragment_count", 32'(fragment_count), 32'(want.fragment_count));
          cmp("event_length_bytes", event_length_bytes, want.event_length_bytes);
          cmp("event_number", event_number, want.event_number);
          cmp("first_station", first_station, want.first_station);
          cmp("event_seconds", event_seconds, want.event_seconds);
          cmp("event_nanosec", 32'(event_nanosec), 32'(want.event_nanosec));
          cmp("event_type", 32'(event_type), 32'(want.event_type));
          cmp("stream", 32'(stream), 32'(want.stream));
          cmp("event_version", event_version, want.event_version);
          cmp("run_id", run_id, want.run_id);
        end
      end
    end
    headers_due <= header_q.size();
    fail_count  <= err_cnt;
  end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// Testbench top of the coincidence event builder: clock, reset, item traffic and verdict.
module tb;
  import ceb_pkg::*;

  // Length of the one long stall of the result side, in clock cycles.
  localparam int HoldCycles   = 300;
  // Least items worked on per random phase; four phases make up the random part.
  localparam int PhaseItems   = 375;

  // One input item as the stimulus builds it before it goes on the ports.
  typedef struct packed {
    cmd_t        cmd;
    logic [31:0] tid;
    logic [31:0] sta;
    logic [31:0] sec;
    logic [29:0] ns;
    logic [31:0] status;
    logic [15:0] words;
    logic [31:0] ver;
  } desc_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic        command = 1'b0;
  logic [31:0] trigger_id = '0;
  logic [31:0] station_id = '0;
  logic [31:0] time_seconds = '0;
  logic [29:0] time_nanosec = '0;
  logic [31:0] trigger_status = '0;
  logic [15:0] length_words = '0;
  logic [31:0] fragment_version = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [31:0] event_trigger_id;
  logic [15:0] fragment_count;
  logic [31:0] event_length_bytes;
  logic [31:0] event_number;
  logic [31:0] first_station;
  logic [31:0] event_seconds;
  logic [29:0] event_nanosec;
  logic [15:0] event_type;
  logic [1:0]  stream;
  logic [31:0] event_version;
  logic [31:0] run_id;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic [31:0] fail_count;
  logic [31:0] headers_due;

  // Idling controls: the sender's chance to idle and the receiver's chance to stall,
  // in percent per cycle, plus the one long hold-off of the result side.
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  logic        hold_req = 1'b0;
  logic        hold_done = 1'b0;
  int          hold_left = 0;

  // Items that the block really works on in the current phase.
  int          items_sent = 0;
  // Mirror of the window register, used to shape fragment times around it.
  logic [29:0] win_ns = WindowReset;
  // Time of the stream; events are built at and after this point.
  logic [31:0] now_sec = '0;
  logic [29:0] now_ns = '0;
  logic [31:0] last_tid = '0;

  coincidence_event_builder i_dut (.*);
  event_header_checker i_checker (.*);

  always #5 clk = ~clk;

  // Result side. It stalls at random per cycle, and once, when asked, holds pop low
  // for a long stretch so that the block fills up and raises full on its input.
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (hold_left != 0) begin
      pop <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      pop <= 1'b0;
      hold_left <= HoldCycles;
      hold_done <= 1'b1;
    end else begin
      pop <= ($urandom_range(99, 0) >= stall_pct);
    end
  end

  // The run never lasts this long when the block works.
  initial begin
    #20_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // Offers one item and returns at the clock edge that accepts it. Idle cycles, when
  // the sender idles, come before the item, so push is never lowered and raised in
  // one step.
  task automatic send(input desc_t d);
    if (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct) begin
      push <= 1'b0;
      do @(posedge clk); while ($urandom_range(99, 0) < send_idle_pct);
    end
    push             <= 1'b1;
    command          <= d.cmd;
    trigger_id       <= d.tid;
    station_id       <= d.sta;
    time_seconds     <= d.sec;
    time_nanosec     <= d.ns;
    trigger_status   <= d.status;
    length_words     <= d.words;
    fragment_version <= d.ver;
    do @(posedge clk); while (full);
    if (!(d.cmd == CMD_FRAGMENT && d.words >= 16'(MaxFragmentWords))) items_sent++;
  endtask

  // Waits until every expected header has come out, then lets the pipeline settle,
  // since fragments that only join an event leave nothing to wait for.
  task automatic wait_idle();
    push <= 1'b0;
    @(posedge clk);
    while (headers_due != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // One APB transfer: the setup phase, the access phase until pready, then an idle step with psel low.
  task automatic apb(input reg_idx_t idx, input logic wr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic read_all();
    for (int i = REG_WINDOW; i <= REG_VERSION; i++) apb(reg_idx_t'(i), 1'b0, '0);
  endtask

  // Writes the whole register set and reads it back; the checker follows both.
  task automatic write_regs(input logic [29:0] w, input logic [15:0] mb,
                            input logic [15:0] rnd, input logic [31:0] run,
                            input logic [7:0] tag);
    win_ns = w;
    apb(REG_WINDOW, 1'b1, {2'b0, w});
    apb(REG_MINBIAS, 1'b1, {16'b0, mb});
    apb(REG_RANDOM, 1'b1, {16'b0, rnd});
    apb(REG_RUN, 1'b1, run);
    apb(REG_VERSION, 1'b1, {24'b0, tag});
    read_all();
  endtask

  function automatic desc_t fragment(input logic [31:0] tid, input logic [31:0] sta,
                                     input logic [31:0] sec, input logic [29:0] ns,
                                     input logic [31:0] status, input logic [15:0] words,
                                     input logic [31:0] ver);
    desc_t d;
    d.cmd = CMD_FRAGMENT;
    d.tid = tid;
    d.sta = sta;
    d.sec = sec;
    d.ns = ns;
    d.status = status;
    d.words = words;
    d.ver = ver;
    return d;
  endfunction

  // Fully random item, out-of-range nanoseconds and oversized lengths included.
  function automatic desc_t noise();
    desc_t d;
    d.cmd = ($urandom_range(1, 0) == 0) ? CMD_FRAGMENT : CMD_FLUSH;
    d.tid = ($urandom_range(1, 0) == 0) ? last_tid : $urandom;
    d.sta = $urandom;
    d.sec = $urandom;
    d.ns = 30'($urandom);
    d.status = $urandom;
    d.words = 16'($urandom);
    d.ver = $urandom;
    return d;
  endfunction

  function automatic desc_t flush_cmd();
    desc_t d;
    d = noise();
    d.cmd = CMD_FLUSH;
    return d;
  endfunction

  // The type field is often zero or a single bit, so that both flags and the
  // single-fragment rule all decide the stream in turn.
  function automatic logic [31:0] rand_status();
    logic [31:0] s;
    s = $urandom;
    case ($urandom_range(2, 0))
      0: s[31:16] = '0;
      1: s[31:16] = 16'd1 << $urandom_range(15, 0);
      default: ;
    endcase
    return s;
  endfunction

  // Mostly legal lengths, with both ends and now and then an oversized fragment.
  function automatic logic [15:0] rand_words();
    case ($urandom_range(19, 0))
      0: return 16'd0;
      1: return 16'(MaxFragmentWords - 1);
      2: return 16'($urandom_range(65535, MaxFragmentWords));
      default: return 16'($urandom_range(MaxFragmentWords - 1, 0));
    endcase
  endfunction

  // Adds at most one second of nanoseconds to a timestamp.
  function automatic logic [61:0] add_ns(input logic [31:0] s, input logic [29:0] n,
                                         input logic [31:0] d);
    logic [31:0] t;
    t = {2'b0, n} + d;
    if (t >= NsPerSec) begin
      s = s + 32'd1;
      t = t - NsPerSec;
    end
    return {s, t[29:0]};
  endfunction

  // A well-formed event: one trigger id, fragments timed from the first one, mostly
  // in its window, with some placed right on or just inside the window edge. The trigger
  // id is sometimes the previous one, so that the time alone decides the split.
  task automatic send_event();
    int          nfrag;
    logic [31:0] tid, d, span;
    logic [61:0] at;
    nfrag = ($urandom_range(9, 0) == 0) ? $urandom_range(12, 7) : $urandom_range(6, 1);
    tid = ($urandom_range(3, 0) == 0) ? last_tid : $urandom;
    last_tid = tid;
    span = {2'b0, win_ns} / 32'(nfrag);
    d = '0;
    at = {now_sec, now_ns};
    for (int k = 0; k < nfrag; k++) begin
      if (k != 0) begin
        case ($urandom_range(9, 0))
          0: d = {2'b0, win_ns};
          1: d = (win_ns == 0) ? 32'd0 : {2'b0, win_ns} - 32'd1;
          default: d = d + $urandom_range(span, 0);
        endcase
        if (d > NsPerSec) d = NsPerSec;
      end
      at = add_ns(now_sec, now_ns, d);
      send(fragment(tid, $urandom, at[61:30], at[29:0], rand_status(), rand_words(),
                    $urandom));
    end
    {now_sec, now_ns} = at;
    if ($urandom_range(3, 0) == 0) send(flush_cmd());
  endtask

  // Random phase: mostly well-formed events at advancing times, some noise items.
  task automatic run_phase(input int n, input int sidle, input int rstall);
    logic [31:0] gap;
    send_idle_pct = sidle;
    stall_pct <= rstall;
    items_sent = 0;
    now_sec = $urandom;
    now_ns = 30'($urandom_range(999999999, 0));
    while (items_sent < n) begin
      if ($urandom_range(99, 0) < 85) begin
        case ($urandom_range(3, 0))
          0: gap = '0;
          1: gap = $urandom_range(win_ns, 0);
          2: gap = $urandom_range(999999999, 0);
          default: begin
            gap = '0;
            now_sec = now_sec + $urandom_range(5, 2);
          end
        endcase
        {now_sec, now_ns} = add_ns(now_sec, now_ns, gap);
        send_event();
      end else begin
        send(noise());
      end
    end
    wait_idle();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Registers hold their reset values, and the directed items run with them.
    read_all();

    // A flush with nothing open and an oversized fragment both leave no trace.
    send(flush_cmd());
    send(fragment(32'h0000_1234, '0, '0, '0, '0, 16'(MaxFragmentWords), '0));
    // Just inside the window joins; exactly on the window edge starts a new event.
    send(fragment('0, '1, '0, '0, '0, '0, '0));
    send(fragment('0, 32'd1, '0, 30'd4999999, '0, 16'(MaxFragmentWords - 1), 32'd1));
    send(fragment('0, 32'd2, '0, 30'd5000000, '0, '0, 32'd2));
    // The largest length is dropped even though it would join.
    send(fragment('0, 32'd3, '0, 30'd5000000, '0, 16'hFFFF, 32'd3));
    // A new trigger id closes a single-fragment event, which goes to the random stream.
    send(fragment('1, 32'd4, '0, 30'd5000000, '0, '0, 32'd4));
    // Minimum bias bit set; the next fragment joins across a second boundary.
    send(fragment(32'd1, 32'd5, 32'd1, 30'd999999000, 32'h0000_0100, 16'd7, '1));
    send(fragment(32'd1, 32'd6, 32'd2, 30'd1000, 32'hFFFF_FEFF, 16'd5, '0));
    send(flush_cmd());
    send(flush_cmd());
    // Out-of-range nanoseconds, a fragment earlier in time that still joins, then
    // seconds far apart and exactly two apart, both of which split.
    send(fragment(32'd2, 32'd7, '1, 30'h3FFF_FFFF, 32'h0002_0000, '0, 32'd8));
    send(fragment(32'd2, 32'd8, '1, 30'h3FFF_FF9B, '0, 16'd1, 32'd9));
    send(fragment(32'd2, 32'd9, 32'd1, '0, '0, 16'd2, 32'd10));
    send(fragment(32'd2, 32'd10, 32'd3, '0, '0, 16'd3, 32'd11));
    send(fragment(32'd3, 32'd11, 32'd3, '0, 32'hFFFF_0000, 16'd4, 32'd12));
    send(flush_cmd());
    // A flush whose other fields are all ones; nothing is open any more.
    send('1);
    wait_idle();

    // Zero window: nothing ever joins. Flags cleared, run and tag at their maximum.
    write_regs('0, '0, '0, '1, 8'hFF);
    run_phase(PhaseItems, 0, 0);

    // A one-second window and all flag bits set; the sender idles.
    write_regs(30'd1000000000, 16'hFFFF, 16'hFFFF, '0, '0);
    run_phase(PhaseItems, 63, 0);

    // Random settings; the receiver stalls and starts with one long hold-off while
    // the sender keeps offering items.
    write_regs(30'($urandom_range(1000000000, 0)), 16'd1 << $urandom_range(15, 0),
               16'd1 << $urandom_range(15, 0), $urandom, 8'($urandom));
    hold_req <= 1'b1;
    run_phase(PhaseItems, 0, 63);

    // Reset-like settings with a fresh run number; both sides idle.
    write_regs(WindowReset, MinbiasReset, RandomReset, $urandom, 8'($urandom));
    run_phase(PhaseItems, 29, 29);

    // Close whatever event is still open and collect its header.
    send_idle_pct = 0;
    stall_pct <= 0;
    send(flush_cmd());
    wait_idle();
    repeat (20) @(posedge clk);

    if (fail_count == 0 && headers_due == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
